// ----- src/rau_pkg.sv -----
// Shared types and constants of the rational arithmetic unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package rau_pkg;

   // Operation codes.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // Result and intermediate widths.
   localparam int RES_WIDTH  = 64;
   localparam int WIDE_WIDTH = 65;
   localparam int DIV_STEPS  = 65;
   localparam int CNT_WIDTH  = 7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;
      logic                 mul_en;
      logic [1:0]           mul_sel;
      logic                 combine;
      logic                 gcd_init;
      logic                 gcd_step;
      logic                 div_init;
      logic                 div_step;
      logic                 out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic zero_den;
      logic num_zero;
      logic gcd_done;
   } stat_type;

   // One result item.
   typedef struct packed {
      logic                 r_negative;
      logic [RES_WIDTH-1:0] r_numerator;
      logic [RES_WIDTH-1:0] r_denominator;
      logic [1:0]           status;
   } result_type;

endpackage

// ----- src/rau_ctrl.sv -----
// Controller of the rational arithmetic unit: sequences multiply, combine,
// binary GCD and exact division steps. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rau_pkg::stat_type stat,
   output rau_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_COMB  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_GCD   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   localparam logic [rau_pkg::CNT_WIDTH-1:0] MUL_LAST = rau_pkg::CNT_WIDTH'(2);
   localparam logic [rau_pkg::CNT_WIDTH-1:0] DIV_LAST =
      rau_pkg::CNT_WIDTH'(rau_pkg::DIV_STEPS - 1);

   logic [2:0]                    state_ff, state_in;
   logic [rau_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                          valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) state_in = S_COMB;
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (stat.zero_den || stat.num_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_FIN;
         end
         S_FIN: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output valid: set on load, cleared when the item is taken.
   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      if (cmd.out_load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- src/rau_datapath.sv -----
// Datapath of the rational arithmetic unit: shared multiplier, cross-product
// combine, binary GCD and two bit-serial divisions. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_datapath #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic [1:0]               op,
   input  logic                     a_negative,
   input  logic [OPERAND_WIDTH-1:0] a_numerator,
   input  logic [OPERAND_WIDTH-1:0] a_denominator,
   input  logic                     b_negative,
   input  logic [OPERAND_WIDTH-1:0] b_numerator,
   input  logic [OPERAND_WIDTH-1:0] b_denominator,
   input  rau_pkg::cmd_type         cmd,
   output rau_pkg::stat_type        stat,
   output rau_pkg::result_type      result
);

   localparam int RW = rau_pkg::RES_WIDTH;
   localparam int WW = rau_pkg::WIDE_WIDTH;

   logic [1:0]               op_ff;
   logic                     an_ff, bn_ff;
   logic [OPERAND_WIDTH-1:0] anum_ff, aden_ff, bnum_ff, bden_ff;
   logic [RW-1:0]            p_ff, q_ff, d_ff;
   logic [WW-1:0]            num_ff;
   logic [RW-1:0]            den_ff;
   logic                     neg_ff;
   logic [WW-1:0]            u_ff, v_ff;
   logic [rau_pkg::CNT_WIDTH-1:0] k_ff;
   logic [RW-1:0]            g_ff;
   logic [WW-1:0]            qn_ff, qd_ff;
   logic [RW-1:0]            rn_ff, rd_ff;
   rau_pkg::result_type      result_ff;

   // Multiplier operand selection for the three product steps.
   logic [OPERAND_WIDTH-1:0]   mul_x, mul_y;
   logic [2*OPERAND_WIDTH-1:0] mul_p;
   always_comb begin
      case (cmd.mul_sel)
         2'd0: begin
            mul_x = anum_ff;
            mul_y = (op_ff == rau_pkg::OP_MUL) ? bnum_ff : bden_ff;
         end
         2'd1: begin
            mul_x = aden_ff;
            mul_y = bnum_ff;
         end
         default: begin
            mul_x = aden_ff;
            mul_y = bden_ff;
         end
      endcase
      mul_p = mul_x * mul_y;
   end

   // Combine cross products into the unreduced numerator and denominator.
   logic          beff;
   logic [WW-1:0] comb_num;
   logic          comb_neg;
   logic [RW-1:0] comb_den;
   always_comb begin
      beff     = (op_ff == rau_pkg::OP_SUB) ? ~bn_ff : bn_ff;
      comb_den = d_ff;
      comb_neg = an_ff ^ bn_ff;
      comb_num = {1'b0, p_ff};
      case (op_ff) inside
         rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            if (an_ff == beff) begin
               comb_num = {1'b0, p_ff} + {1'b0, q_ff};
               comb_neg = an_ff;
            end else if (p_ff > q_ff) begin
               comb_num = {1'b0, p_ff - q_ff};
               comb_neg = an_ff;
            end else begin
               comb_num = {1'b0, q_ff - p_ff};
               comb_neg = beff;
            end
         end
         rau_pkg::OP_DIV: comb_den = q_ff;
         default: ;
      endcase
   end

   // One binary GCD step.
   logic [WW-1:0] u_next, v_next;
   logic          k_inc;
   always_comb begin
      u_next = u_ff;
      v_next = v_ff;
      k_inc  = 1'b0;
      if (!u_ff[0] && !v_ff[0]) begin
         u_next = u_ff >> 1;
         v_next = v_ff >> 1;
         k_inc  = 1'b1;
      end else if (!u_ff[0]) begin
         u_next = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_next = v_ff >> 1;
      end else if (u_ff > v_ff) begin
         u_next = u_ff - v_ff;
      end else begin
         v_next = v_ff - u_ff;
      end
   end

   logic [WW-1:0] g_full;
   assign g_full = u_ff << k_ff;

   // One restoring division step for each of the two quotients.
   logic [WW-1:0] rn_sh, rd_sh;
   logic          n_ge, d_ge;
   assign rn_sh = {rn_ff, qn_ff[WW-1]};
   assign rd_sh = {rd_ff, qd_ff[WW-1]};
   assign n_ge  = rn_sh >= {1'b0, g_ff};
   assign d_ge  = rd_sh >= {1'b0, g_ff};

   // Final result selection.
   rau_pkg::result_type res_sel;
   logic                zero_den;
   always_comb begin
      zero_den = (aden_ff == '0) || (bden_ff == '0) ||
                 ((op_ff == rau_pkg::OP_DIV) && (bnum_ff == '0));
      res_sel  = '0;
      if (zero_den) begin
         res_sel.status = rau_pkg::ST_ZERO_DEN;
      end else if (num_ff == '0) begin
         res_sel.r_denominator = RW'(1);
      end else if (qn_ff[WW-1]) begin
         res_sel.status = rau_pkg::ST_OVERFLOW;
      end else begin
         res_sel.r_negative    = neg_ff;
         res_sel.r_numerator   = qn_ff[RW-1:0];
         res_sel.r_denominator = qd_ff[RW-1:0];
         res_sel.status        = rau_pkg::ST_OK;
      end
   end

   assign stat.zero_den = zero_den;
   assign stat.num_zero = (num_ff == '0);
   assign stat.gcd_done = (u_ff == v_ff);
   assign result        = result_ff;

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op;
         an_ff   <= a_negative;
         bn_ff   <= b_negative;
         anum_ff <= a_numerator;
         aden_ff <= a_denominator;
         bnum_ff <= b_numerator;
         bden_ff <= b_denominator;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            2'd0:    p_ff <= RW'(mul_p);
            2'd1:    q_ff <= RW'(mul_p);
            default: d_ff <= RW'(mul_p);
         endcase
      end
      if (cmd.combine) begin
         num_ff <= comb_num;
         den_ff <= comb_den;
         neg_ff <= comb_neg;
      end
      if (cmd.gcd_init) begin
         u_ff <= num_ff;
         v_ff <= {1'b0, den_ff};
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_next;
         v_ff <= v_next;
         if (k_inc) k_ff <= k_ff + 1'b1;
      end
      if (cmd.div_init) begin
         g_ff  <= g_full[RW-1:0];
         qn_ff <= num_ff;
         qd_ff <= {1'b0, den_ff};
         rn_ff <= '0;
         rd_ff <= '0;
      end else if (cmd.div_step) begin
         qn_ff <= {qn_ff[WW-2:0], n_ge};
         qd_ff <= {qd_ff[WW-2:0], d_ge};
         rn_ff <= n_ge ? RW'(rn_sh - {1'b0, g_ff}) : rn_sh[RW-1:0];
         rd_ff <= d_ge ? RW'(rd_sh - {1'b0, g_ff}) : rd_sh[RW-1:0];
      end
      if (cmd.out_load) result_ff <= res_sel;
   end

endmodule

// ----- src/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: stream ports, field packing,
// controller and datapath. Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Usage: an item on the req_ channel carries an operation in req_tuser and
// two sign-magnitude rationals in req_tdata. One result item per input item
// leaves on the rsp_ channel: a rational reduced to lowest terms in
// rsp_tdata and a status code in rsp_tuser (ok, zero denominator, overflow).
// Zero results come out as +0/1; error results have all rsp_tdata fields zero.
// Each item runs three multiplier steps, a combine and a check step, a binary
// GCD (one shift or subtract on 65-bit terms per cycle), then bit-serial
// division for both terms in parallel; the output register is loaded once
// it is free or its previous result is being taken.
// Zero-denominator and zero-numerator items skip the GCD and division.
// One item is in work at a time; req_tready is high only while idle.
// The result sits in an output register, so the next item is accepted
// while the previous result waits; a stalled receiver holds rsp_tdata.
// Reset is synchronous and clears the controller and the output valid.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_negative[0], a_numerator[32:1], a_denominator[64:33], b_negative[65],
   // b_numerator[97:66], b_denominator[129:98], zero fill above
   input  logic [135:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r_negative[0], r_numerator[64:1], r_denominator[128:65], zero fill above
   output logic [135:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   rau_pkg::cmd_type    cmd;
   rau_pkg::stat_type   stat;
   rau_pkg::result_type result;

   // Controller.
   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath; operand fields are taken in their low OPERAND_WIDTH bits.
   rau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .op            (req_tuser),
      .a_negative    (req_tdata[0]),
      .a_numerator   (req_tdata[OPERAND_WIDTH:1]),
      .a_denominator (req_tdata[OPERAND_WIDTH+32:33]),
      .b_negative    (req_tdata[65]),
      .b_numerator   (req_tdata[OPERAND_WIDTH+65:66]),
      .b_denominator (req_tdata[OPERAND_WIDTH+97:98]),
      .cmd           (cmd),
      .stat          (stat),
      .result        (result)
   );

   // Result packing.
   assign rsp_tdata = {7'd0, result.r_denominator, result.r_numerator, result.r_negative};
   assign rsp_tuser = result.status;

endmodule
